// ===== rtl/bounded_list_engine_defines.svh =====
// Assertion macros for the bounded list engine.
// Included by the top level; depends on nothing else.
`ifndef BOUNDED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_LIST_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded_list_engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_list_engine: next-cycle check failed");

`endif

// ===== rtl/ble_pkg.sv =====
// Shared types, command codes and the command classifier of the list engine.
// Used by ble_back and bounded_list_engine; depends on nothing.
`default_nettype none

package ble_pkg;

    localparam logic [1:0] CMD_FRONT  = 2'd0;
    localparam logic [1:0] CMD_BACK   = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    typedef enum logic [1:0] {
        OP_FRONT,
        OP_BACK,
        OP_DELETE,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
        logic [7:0]  index;
    } cmd_t;

    typedef struct packed {
        logic [31:0] element;
        logic        list_empty;
        logic        last;
        logic        insert_dropped;
    } res_t;

    function automatic op_t classify(input logic [1:0] code);
        op_t op;
        case (code)
            CMD_FRONT:  op = OP_FRONT;
            CMD_BACK:   op = OP_BACK;
            CMD_DELETE: op = OP_DELETE;
            default:    op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bounded_list_engine.sv =====
// Bounded list engine: command queue in front, list memory and sequencer behind,
// result queue at the output. Depends on ble_pkg, ble_fifo, ble_back and the defines header.
//
// Usage:
//   Commands enter through a queue port: cmd, value and index are taken at a clock
//   edge with push high and full low. A two-entry command queue decouples the
//   sender from the list sequencer.
//   Results leave through a queue port: while empty is low the oldest result is on
//   element, list_empty, last and insert_dropped, and pop high takes it.
//   Each command produces its whole list, front to back, with last marking the
//   final word; an empty list gives a single word with list_empty set.
//   Sequencing: a command is applied in the idle state, then the emit state issues one
//   memory read per element (an empty list gives its single word with no read), each
//   read waiting for room in the result queue, and the next command waits until the read
//   register has drained. The single read port of the list memory sets this pace.
//   Order: a command at the head of the command queue is taken in the idle state, its first
//   element is read in the emit state and passes the read register to the result queue.
//   When the receiver stalls, a four-word result queue fills and the sequencer
//   pauses; commands keep queueing until the command queue is full.
//   Reset empties both queues and the list; memory contents are not cleared, as
//   entries beyond the list length are never read.
`default_nettype none
`include "bounded_list_engine_defines.svh"

module bounded_list_engine #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    input  logic [7:0]         index,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] element,
    output logic               list_empty,
    output logic               last,
    output logic               insert_dropped
);

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    ble_pkg::cmd_t                  cmd_in;
    ble_pkg::cmd_t                  cmd_head;
    logic                           cmd_q_empty;
    logic                           cmd_pop;
    logic [$clog2(RES_DEPTH+1)-1:0] res_level;
    logic                           res_push;
    logic                           res_full;
    ble_pkg::res_t                  res_in;
    ble_pkg::res_t                  res_out;

    assign cmd_in.op    = ble_pkg::classify(cmd);
    assign cmd_in.value = value;
    assign cmd_in.index = index;

    ble_fifo #(
        .WIDTH ($bits(ble_pkg::cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_head),
        .empty (cmd_q_empty),
        .level ()
    );

    ble_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .RES_DEPTH  (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_q_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_level (res_level),
        .res_push  (res_push),
        .res       (res_in)
    );

    ble_fifo #(
        .WIDTH ($bits(ble_pkg::res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty),
        .level (res_level)
    );

    assign element        = res_out.element;
    assign list_empty     = res_out.list_empty;
    assign last           = res_out.last;
    assign insert_dropped = res_out.insert_dropped;

    // The credit check must keep every result word from meeting a full queue.
    `BLE_ASSERT_SAME(a_no_res_overflow, clk, rst_n, res_push, !res_full)
    `BLE_ASSERT_SAME(a_cmd_pop_valid, clk, rst_n, cmd_pop, !cmd_q_empty)
    `BLE_ASSERT_SAME(a_empty_word, clk, rst_n, !empty && list_empty,
                     last && (element == 32'sd0) && !insert_dropped)
    `BLE_ASSERT_NEXT(a_one_cmd_at_once, clk, rst_n, cmd_pop, !cmd_pop)

endmodule

`default_nettype wire

// ===== rtl/ble_fifo.sv =====
// Small synchronous queue built from registers, used for commands and results.
// Depends on nothing; DEPTH must be a power of two of at least two.
`default_nettype none

module ble_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [LW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == LW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign rdata   = store_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + PW'(1) : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + PW'(1) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + LW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ble_back.sv =====
// Back end of the list engine: holds the list in a circular memory, applies one
// command at a time and streams the list out. Depends on ble_pkg.
`default_nettype none

module ble_back #(
    parameter int CAPACITY  = 32,
    parameter int DATA_WIDTH = 32,
    parameter int RES_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  ble_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    input  logic [$clog2(RES_DEPTH+1)-1:0] res_level,
    output logic                           res_push,
    output ble_pkg::res_t                  res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int LW = $clog2(RES_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic                  del_reg, del_next;
    logic [CW-1:0]         del_idx_reg, del_idx_next;
    logic                  dropped_reg, dropped_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  rd_last_reg, rd_last_next;
    logic                  rd_empty_reg, rd_empty_next;
    logic                  rd_dropped_reg, rd_dropped_next;
    logic                  wb_en_reg, wb_en_next;
    logic [AW-1:0]         wb_addr_reg, wb_addr_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] list_mem [CAPACITY];

    logic                  rd_issue;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  credit;
    logic                  past_hole;
    logic [63:0]           wide_data;

    // Both operands stay below CAPACITY, so one conditional subtract wraps the sum.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(offset);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] base);
        return (base == '0) ? AW'(CAPACITY - 1) : base - AW'(1);
    endfunction

    // A read is only issued when its result is sure to find room in the result queue.
    assign credit    = ((LW + 1)'(res_level) + (LW + 1)'(rd_valid_reg)) < (LW + 1)'(RES_DEPTH);
    assign past_hole = del_reg && (pos_reg >= del_idx_reg);
    assign wide_data = 64'(rd_data_reg);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        del_next        = del_reg;
        del_idx_next    = del_idx_reg;
        dropped_next    = dropped_reg;
        rd_valid_next   = 1'b0;
        rd_last_next    = rd_last_reg;
        rd_empty_next   = rd_empty_reg;
        rd_dropped_next = rd_dropped_reg;
        wb_en_next      = 1'b0;
        wb_addr_next    = wb_addr_reg;
        cmd_pop         = 1'b0;
        rd_issue        = 1'b0;
        rd_addr         = head_reg;
        mem_we          = 1'b0;
        mem_waddr       = wb_addr_reg;
        mem_wdata       = rd_data_reg;

        // During a delete pass each element behind the hole moves one place forward.
        if (rd_valid_reg && wb_en_reg)
        begin
            mem_we = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !rd_valid_reg)
                begin
                    cmd_pop      = 1'b1;
                    dropped_next = 1'b0;
                    del_next     = 1'b0;
                    pos_next     = '0;
                    state_next   = S_EMIT;
                    case (cmd.op)
                        ble_pkg::OP_FRONT, ble_pkg::OP_BACK:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = DATA_WIDTH'(cmd.value);
                                count_next = count_reg + CW'(1);
                                if (cmd.op == ble_pkg::OP_FRONT)
                                begin
                                    head_next = wrap_dec(head_reg);
                                    mem_waddr = wrap_dec(head_reg);
                                end
                                else
                                begin
                                    mem_waddr = wrap_add(head_reg, count_reg);
                                end
                            end
                        end
                        ble_pkg::OP_DELETE:
                        begin
                            if (16'(cmd.index) < 16'(count_reg))
                            begin
                                del_next     = 1'b1;
                                del_idx_next = CW'(cmd.index);
                                count_next   = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (credit)
                begin
                    rd_valid_next   = 1'b1;
                    rd_dropped_next = dropped_reg;
                    if (count_reg == '0)
                    begin
                        rd_empty_next = 1'b1;
                        rd_last_next  = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        rd_issue      = 1'b1;
                        rd_empty_next = 1'b0;
                        rd_addr       = wrap_add(head_reg,
                                                 past_hole ? pos_reg + CW'(1) : pos_reg);
                        wb_en_next    = past_hole;
                        wb_addr_next  = wrap_add(head_reg, pos_reg);
                        rd_last_next  = (pos_reg == count_reg - CW'(1));
                        pos_next      = pos_reg + CW'(1);
                        if (pos_reg == count_reg - CW'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            del_reg        <= 1'b0;
            del_idx_reg    <= '0;
            dropped_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            rd_empty_reg   <= 1'b0;
            rd_dropped_reg <= 1'b0;
            wb_en_reg      <= 1'b0;
            wb_addr_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            del_reg        <= del_next;
            del_idx_reg    <= del_idx_next;
            dropped_reg    <= dropped_next;
            rd_valid_reg   <= rd_valid_next;
            rd_last_reg    <= rd_last_next;
            rd_empty_reg   <= rd_empty_next;
            rd_dropped_reg <= rd_dropped_next;
            wb_en_reg      <= wb_en_next;
            wb_addr_reg    <= wb_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            list_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_issue)
        begin
            rd_data_reg <= list_mem[rd_addr];
        end
    end

    assign res_push           = rd_valid_reg;
    assign res.element        = rd_empty_reg ? 32'd0 : wide_data[31:0];
    assign res.list_empty     = rd_empty_reg;
    assign res.last           = rd_last_reg;
    assign res.insert_dropped = rd_dropped_reg;

endmodule

`default_nettype wire
